### rtl/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// shared types and constants of the piecewise linear interpolation table
// ----------------------------------------------------------------------------
package pli_pkg;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_EVAL  = 1'b1;

  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned DIV_STEPS = 33;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    ST_VALUE   = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_WRITTEN = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_SCAN,
    S_MUL,
    S_DIV,
    S_RESP
  } state_e;

  typedef struct packed {
    logic               mode;
    logic [SLOT_W-1:0]  point_index;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] y_result;
    status_e            status;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } point_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [32:0] quotient;
  } div_rsp_t;

endpackage

### rtl/piecewise_linear_interp.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interp
// breakpoint table with linear interpolation between bracketing points
// ----------------------------------------------------------------------------
// a write transfer goes from accept straight to the result state
// an evaluation ends early when clamped to the first or last point; otherwise
// it scans the segments with one table read per cycle, then multiplies and
// divides in the serial divider
// one item at a time; a new item is taken while the last result waits
// reset clears the point count and control state; table contents stay unknown
module piecewise_linear_interp #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pli_pkg::COUNT_W-1:0]       cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  pli_pkg::in_item_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output pli_pkg::out_item_t                out_data_o
);
  import pli_pkg::*;

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  state_e                state_q, state_d;
  logic [COUNT_W-1:0]    count_q;
  logic [CW-1:0]         n_c;
  logic                  slot_ok;

  logic signed [31:0]    q_q, q_d;
  logic signed [31:0]    px_q, px_d;
  logic signed [31:0]    py_q, py_d;
  logic signed [31:0]    dflt_q, dflt_d;
  logic [AW-1:0]         last_q, last_d;
  logic [AW-1:0]         k_q, k_d;
  logic [31:0]           width_q, width_d;
  logic [31:0]           along_q, along_d;
  logic [31:0]           mag_q, mag_d;
  logic                  neg_q, neg_d;
  logic signed [31:0]    res_y_q, res_y_d;
  status_e               res_st_q, res_st_d;
  logic signed [32:0]    dy;
  logic [63:0]           prod_w;

  logic                  wr_en;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  point_t                wr_data;
  point_t                rd_data;
  div_req_t              div_req;
  div_rsp_t              div_rsp;

  logic                  out_valid_q;
  out_item_t             out_data_q;
  logic                  out_load;

  pli_table #(
    .DEPTH(MAX_POINTS)
  ) u_table (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(AW'(in_data_i.point_index)),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  pli_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_valid_i) begin
      count_q <= cfg_data_i;
    end
  end

  assign n_c     = (32'(count_q) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(count_q);
  assign slot_ok = (32'(in_data_i.point_index) < MAX_POINTS);
  assign wr_data = '{x: in_data_i.x_value, y: in_data_i.y_value};

  assign dy     = {rd_data.y[31], rd_data.y} - {py_q[31], py_q};
  assign prod_w = mag_q * along_q;

  assign out_load = (state_q == S_RESP) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d          = state_q;
    in_ready_o       = 1'b0;
    wr_en            = 1'b0;
    rd_en            = 1'b0;
    rd_addr          = '0;
    div_req.start    = 1'b0;
    div_req.dividend = prod_w;
    div_req.divisor  = width_q;
    q_d              = q_q;
    px_d             = px_q;
    py_d             = py_q;
    dflt_d           = dflt_q;
    last_d           = last_q;
    k_d              = k_q;
    width_d          = width_q;
    along_d          = along_q;
    mag_d            = mag_q;
    neg_d            = neg_q;
    res_y_d          = res_y_q;
    res_st_d         = res_st_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          q_d = in_data_i.x_value;
          if (in_data_i.mode == MODE_WRITE) begin
            wr_en    = slot_ok;
            res_y_d  = '0;
            res_st_d = ST_WRITTEN;
            state_d  = S_RESP;
          end else if (n_c == '0) begin
            res_y_d  = '0;
            res_st_d = ST_EMPTY;
            state_d  = S_RESP;
          end else begin
            rd_en   = 1'b1;
            rd_addr = '0;
            last_d  = AW'(n_c - 1'b1);
            state_d = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        px_d     = rd_data.x;
        py_d     = rd_data.y;
        res_st_d = ST_VALUE;
        if (last_q == '0 || q_q <= rd_data.x) begin
          res_y_d = rd_data.y;
          state_d = S_RESP;
        end else begin
          rd_en   = 1'b1;
          rd_addr = last_q;
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        if (q_q >= rd_data.x) begin
          res_y_d = rd_data.y;
          state_d = S_RESP;
        end else begin
          dflt_d  = rd_data.y;
          rd_en   = 1'b1;
          rd_addr = AW'(1);
          k_d     = AW'(1);
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (q_q >= px_q && q_q <= rd_data.x) begin
          if (rd_data.x == px_q) begin
            res_y_d = py_q;
            state_d = S_RESP;
          end else begin
            width_d = 32'(rd_data.x - px_q);
            along_d = 32'(q_q - px_q);
            neg_d   = dy[32];
            mag_d   = dy[32] ? 32'(-dy) : 32'(dy);
            state_d = S_MUL;
          end
        end else if (k_q == last_q) begin
          res_y_d = dflt_q;
          state_d = S_RESP;
        end else begin
          px_d    = rd_data.x;
          py_d    = rd_data.y;
          k_d     = AW'(k_q + 1'b1);
          rd_en   = 1'b1;
          rd_addr = AW'(k_q + 1'b1);
        end
      end
      S_MUL: begin
        div_req.start = 1'b1;
        state_d       = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          res_y_d = neg_q ? (py_q - $signed(div_rsp.quotient[31:0]))
                          : (py_q + $signed(div_rsp.quotient[31:0]));
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q      <= q_d;
    px_q     <= px_d;
    py_q     <= py_d;
    dflt_q   <= dflt_d;
    last_q   <= last_d;
    k_q      <= k_d;
    width_q  <= width_d;
    along_q  <= along_d;
    mag_q    <= mag_d;
    neg_q    <= neg_d;
    res_y_q  <= res_y_d;
    res_st_q <= res_st_d;
  end

  // output register, parts the result from the next item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= '{y_result: res_y_q, status: res_st_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DIV)
    else $error("divider finished outside the divide state");

  a_write_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.mode == MODE_WRITE)
      |=> (state_q == S_RESP && res_st_q == ST_WRITTEN))
    else $error("write transfer did not go straight to response");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> k_q <= last_q)
    else $error("segment scan ran past the last point");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ST_EMPTY) |-> out_data_o.y_result == '0)
    else $error("empty table result carries a value");

  a_start_from_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |=> state_q == S_DIV)
    else $error("divider started without entering the divide state");

endmodule

### rtl/pli_table.sv
// ----------------------------------------------------------------------------
// pli_table
// breakpoint memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module pli_table #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  pli_pkg::point_t          wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output pli_pkg::point_t          rd_data_o
);
  import pli_pkg::*;

  point_t mem_q [DEPTH];
  point_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/pli_div.sv
// ----------------------------------------------------------------------------
// pli_div
// restoring divider, one quotient bit per cycle, 33 quotient bits
// ----------------------------------------------------------------------------
module pli_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pli_pkg::div_req_t req_i,
  output pli_pkg::div_rsp_t rsp_o
);
  import pli_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0]          rem_q, rem_d;
  logic [32:0]          num_q, num_d;
  logic [32:0]          quo_q, quo_d;
  logic [31:0]          dvs_q, dvs_d;
  logic [32:0]          rem_sh;
  logic [33:0]          diff;

  assign rem_sh = {rem_q, num_q[32]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = {1'b0, req_i.dividend[63:33]};
      num_d  = req_i.dividend[32:0];
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      num_d = {num_q[31:0], 1'b0};
      if (!diff[33]) begin
        rem_d = diff[31:0];
        quo_d = {quo_q[31:0], 1'b1};
      end else begin
        rem_d = rem_sh[31:0];
        quo_d = {quo_q[31:0], 1'b0};
      end
      cnt_d = DIV_CNT_W'(cnt_q + 1'b1);
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o = '{done: done_q, quotient: quo_q};

endmodule
